/* hw/rtl/x86cj_pkg.sv */
// ----------------------------------------------------------------------------
// x86cj_pkg
// Shared types and constants for the x86 call/jump address unfilter.
// ----------------------------------------------------------------------------
package x86cj_pkg;

  // window geometry
  localparam int WINDOW_BYTES = 5;
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);

  // opcode bytes that carry a relative operand
  localparam logic [7:0] OPC_CALL = 8'hE8;
  localparam logic [7:0] OPC_JUMP = 8'hE9;

  // operand lengths in bytes
  localparam logic [FILL_W-1:0] SKIP_SHORT = FILL_W'(2);
  localparam logic [FILL_W-1:0] SKIP_LONG  = FILL_W'(4);

  // config bus
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_OPERAND_MODE   = 1'b0;
  localparam logic REG_START_POSITION = 1'b1;

  typedef logic [31:0] pos_t;

  // one restored byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  // window to output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

/* hw/rtl/x86cj_window.sv */
// ----------------------------------------------------------------------------
// x86cj_window
// Five-byte hold window: one byte per cycle in while in_ready, one out while
// out_space; holds an opcode until its operand is complete and translates it.
// ----------------------------------------------------------------------------
module x86cj_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  input  logic                 operand_mode,
  input  x86cj_pkg::pos_t      start_position,
  input  logic                 start_load,
  input  logic                 out_space,
  output x86cj_pkg::emit_t     emit
);

  // window state
  logic [7:0]                      win [x86cj_pkg::WINDOW_BYTES];
  logic [7:0]                      win_next [x86cj_pkg::WINDOW_BYTES];
  logic [x86cj_pkg::FILL_W-1:0]    fill;
  logic [x86cj_pkg::FILL_W-1:0]    fill_next;
  logic [x86cj_pkg::FILL_W-1:0]    skip;
  logic [x86cj_pkg::FILL_W-1:0]    skip_next;
  x86cj_pkg::pos_t                 pos;
  x86cj_pkg::pos_t                 pos_next;
  logic                            flush;
  logic                            flush_next;

  // per-cycle decisions
  logic [7:0]                      head;
  logic                            is_opc;
  logic                            long_op;
  logic                            full;
  logic                            hold_head;
  logic                            pop;
  logic                            push;
  logic                            translate;
  logic                            last_pop;
  logic [31:0]                     operand;
  logic [31:0]                     diff;
  logic [7:0]                      patched [x86cj_pkg::WINDOW_BYTES];
  logic [7:0]                      shifted [x86cj_pkg::WINDOW_BYTES];
  logic [x86cj_pkg::FILL_W-1:0]    fill_mid;

  // head decode and handshake
  always_comb begin
    head      = win[0];
    is_opc    = (head == x86cj_pkg::OPC_CALL) || (head == x86cj_pkg::OPC_JUMP);
    long_op   = (head == x86cj_pkg::OPC_CALL) && operand_mode;
    full      = (fill == x86cj_pkg::FILL_W'(x86cj_pkg::WINDOW_BYTES));
    hold_head = (fill != '0) && (skip == '0) && is_opc && !full && !flush;
    pop       = (fill != '0) && !hold_head && out_space;
    translate = pop && (skip == '0) && is_opc && full;
    last_pop  = pop && flush && (fill == x86cj_pkg::FILL_W'(1));
    in_ready  = !flush && (!full || out_space);
    push      = in_valid && in_ready;
  end

  // operand minus head position, one subtractor for both widths
  always_comb begin
    operand = long_op ? {win[4], win[3], win[2], win[1]} : {16'h0000, win[2], win[1]};
    diff    = operand - pos;
  end

  // patch operand, shift out the head, append the new byte
  always_comb begin
    for (int i = 0; i < x86cj_pkg::WINDOW_BYTES; i++) begin
      patched[i] = win[i];
    end
    if (translate) begin
      patched[1] = diff[7:0];
      patched[2] = diff[15:8];
      if (long_op) begin
        patched[3] = diff[23:16];
        patched[4] = diff[31:24];
      end
    end
    for (int i = 0; i < x86cj_pkg::WINDOW_BYTES - 1; i++) begin
      shifted[i] = pop ? patched[i + 1] : patched[i];
    end
    shifted[x86cj_pkg::WINDOW_BYTES - 1] =
      pop ? 8'h00 : patched[x86cj_pkg::WINDOW_BYTES - 1];
    fill_mid = fill - x86cj_pkg::FILL_W'(pop);
    for (int i = 0; i < x86cj_pkg::WINDOW_BYTES; i++) begin
      win_next[i] = (push && (fill_mid == x86cj_pkg::FILL_W'(i))) ? data_byte : shifted[i];
    end
    fill_next = fill_mid + x86cj_pkg::FILL_W'(push);
  end

  // skip count, position and end-of-stream flush
  always_comb begin
    skip_next  = skip;
    pos_next   = pos;
    flush_next = flush;
    if (translate) begin
      skip_next = long_op ? x86cj_pkg::SKIP_LONG : x86cj_pkg::SKIP_SHORT;
    end else if (pop && (skip != '0)) begin
      skip_next = skip - x86cj_pkg::FILL_W'(1);
    end
    if (pop) begin
      pos_next = pos + 32'd1;
    end
    if (push && end_of_stream) begin
      flush_next = 1'b1;
    end
    if (last_pop) begin
      flush_next = 1'b0;
      skip_next  = '0;
      pos_next   = start_position;
    end
    if (start_load) begin
      pos_next = start_position;
    end
  end

  // released byte
  always_comb begin
    emit.valid     = pop;
    emit.item.data = head;
    emit.item.last = flush && (fill == x86cj_pkg::FILL_W'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      skip  <= '0;
      pos   <= '0;
      flush <= 1'b0;
    end else begin
      fill  <= fill_next;
      skip  <= skip_next;
      pos   <= pos_next;
      flush <= flush_next;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < x86cj_pkg::WINDOW_BYTES; i++) begin
      win[i] <= win_next[i];
    end
  end

endmodule

/* hw/rtl/x86_call_jump_address_unfilter_core.sv */
// ----------------------------------------------------------------------------
// x86_call_jump_address_unfilter_core
// Undoes the x86 call/jump address filter on a byte stream.
// ----------------------------------------------------------------------------
// an accepted byte is registered in the window, then in the output buffer
// throughput: 1 byte per cycle (one window pop each) unless held or stalled
// an 0xE8/0xE9 byte is held until four more bytes arrive; after an end item
// the window drains up to 5 bytes, one per cycle with out_space, in_ready low
// reset: window and output buffer empty, operand_mode and start_position zero
// ----------------------------------------------------------------------------
module x86_call_jump_address_unfilter_core (
  input  logic                         clk,
  input  logic                         rst,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [x86cj_pkg::ADDR_W-1:0] paddr,
  input  logic [x86cj_pkg::DATA_W-1:0] pwdata,
  output logic [x86cj_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_stream,
  // output items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last
);

  // config registers
  logic                    operand_mode;
  x86cj_pkg::pos_t         start_position;
  x86cj_pkg::pos_t         start_now;
  logic                    cfg_write;
  logic                    reg_sel;
  logic                    start_load;

  // output buffer
  x86cj_pkg::out_item_t    slot0;
  x86cj_pkg::out_item_t    slot0_next;
  x86cj_pkg::out_item_t    slot1;
  x86cj_pkg::out_item_t    slot1_next;
  logic [1:0]              cnt;
  logic [1:0]              cnt_next;
  logic                    take;
  logic                    out_space;
  x86cj_pkg::emit_t        emit;

  // config decode; a start write hands the new value to the window directly
  always_comb begin
    pready     = 1'b1;
    reg_sel    = paddr[2];
    cfg_write  = psel && penable && pwrite;
    start_load = cfg_write && (reg_sel == x86cj_pkg::REG_START_POSITION);
    start_now  = start_load ? pwdata : start_position;
  end

  // register read
  always_comb begin
    unique case (reg_sel)
      x86cj_pkg::REG_OPERAND_MODE:   prdata = {31'b0, operand_mode};
      x86cj_pkg::REG_START_POSITION: prdata = start_position;
      default:                       prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      operand_mode   <= 1'b0;
      start_position <= '0;
    end else if (cfg_write) begin
      if (reg_sel == x86cj_pkg::REG_OPERAND_MODE) begin
        operand_mode <= pwdata[0];
      end else begin
        start_position <= pwdata;
      end
    end
  end

  // hold window
  x86cj_window u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .operand_mode   (operand_mode),
    .start_position (start_now),
    .start_load     (start_load),
    .out_space      (out_space),
    .emit           (emit)
  );

  // two-entry output buffer
  always_comb begin
    take       = out_valid && out_ready;
    out_space  = (cnt != 2'd2);
    slot0_next = slot0;
    slot1_next = slot1;
    cnt_next   = cnt;
    unique case ({take, emit.valid})
      2'b01: begin
        if (cnt == 2'd0) begin
          slot0_next = emit.item;
        end else begin
          slot1_next = emit.item;
        end
        cnt_next = cnt + 2'd1;
      end
      2'b10: begin
        slot0_next = slot1;
        cnt_next   = cnt - 2'd1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          slot0_next = emit.item;
        end else begin
          slot0_next = slot1;
          slot1_next = emit.item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  // output port
  always_comb begin
    out_valid = (cnt != 2'd0);
    out_byte  = slot0.data;
    out_last  = slot0.last;
  end

  // a full buffer holds the window back
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !emit.valid)
    else $error("window released a byte into a full output buffer");

  // no new item while the window drains after an end item
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_stream) |=> !in_ready)
    else $error("input taken during end-of-stream drain");

  // after the last byte leaves the window a new stream may start
  assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.item.last) |=> in_ready)
    else $error("window not ready after end of stream");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the x86 call/jump address unfilter core.
// A short table of hand-picked bytes and register writes runs first, then
// random byte streams in four traffic phases. Every accepted input byte goes
// through a local model of the hold window; its bytes, or a row's typed byte,
// are queued and matched field by field against the core's output items.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 78;
  localparam int PLAN_ROWS    = 24;

  typedef enum logic [1:0] {ROW_ITEM, ROW_MODE, ROW_START} row_kind_e;
  // how an item's restored bytes are known: from the model, none, or one typed byte
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} chk_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        eos;
    logic [31:0] value;
    chk_e        chk;
    logic [7:0]  exp_byte;
    logic        exp_last;
  } plan_row_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [x86cj_pkg::ADDR_W-1:0] paddr = '0;
  logic [x86cj_pkg::DATA_W-1:0] pwdata = '0;
  logic [x86cj_pkg::DATA_W-1:0] prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   data_byte = 8'h00;
  logic                         end_of_stream = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_byte;
  logic                         out_last;

  // typed expectation travels with the payload
  chk_e       pend_chk = CHK_PRED;
  logic [7:0] pend_byte = 8'h00;
  logic       pend_last = 1'b0;

  // traffic shaping, percent per cycle
  int send_idle = 0;
  int recv_stall = 0;

  // window model
  logic [7:0]  win [x86cj_pkg::WINDOW_BYTES];
  int unsigned win_fill = 0;
  int unsigned operand_left = 0;
  logic [31:0] head_pos = '0;
  logic [31:0] start_pos = '0;
  logic        wide_call = 1'b0;

  x86cj_pkg::out_item_t step_out [$];
  x86cj_pkg::out_item_t restored_q [$];

  int errors = 0;
  int items_in = 0;
  int bytes_out = 0;
  int translations = 0;
  int wide_translations = 0;
  int stream_ends = 0;
  int reg_writes = 0;
  int stuck_cycles = 0;

  x86_call_jump_address_unfilter_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one input byte through the window; restored bytes land in step_out
  function automatic void unfilter_step(input logic [7:0] b, input logic eos);
    logic [7:0]           hd;
    logic [31:0]          operand;
    int unsigned          len;
    int                   k;
    x86cj_pkg::out_item_t r;
    win[win_fill] = b;
    win_fill++;
    while (win_fill > 0) begin
      hd = win[0];
      if (operand_left == 0 &&
          (hd == x86cj_pkg::OPC_CALL || hd == x86cj_pkg::OPC_JUMP)) begin
        if (win_fill == x86cj_pkg::WINDOW_BYTES) begin
          // subtract the opcode position from the little-endian operand
          len = (hd == x86cj_pkg::OPC_CALL && wide_call) ? 4 : 2;
          operand = '0;
          for (k = 0; k < len; k++) operand |= 32'(win[1+k]) << (8 * k);
          operand -= head_pos;
          for (k = 0; k < len; k++) win[1+k] = operand[8*k +: 8];
          operand_left = len;
          translations++;
          if (len == 4) wide_translations++;
        end else if (!eos) begin
          break;
        end
      end else if (operand_left > 0) begin
        operand_left--;
      end
      r.data = hd;
      r.last = eos && (win_fill == 1);
      step_out.push_back(r);
      for (k = 0; k < x86cj_pkg::WINDOW_BYTES - 1; k++) win[k] = win[k+1];
      win[x86cj_pkg::WINDOW_BYTES-1] = 8'h00;
      win_fill--;
      head_pos++;
    end
    // end of stream empties everything and rewinds the position
    if (eos) begin
      win_fill = 0;
      operand_left = 0;
      for (k = 0; k < x86cj_pkg::WINDOW_BYTES; k++) win[k] = 8'h00;
      head_pos = start_pos;
      stream_ends++;
    end
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // output check and input prediction
  always @(posedge clk) begin : monitor
    x86cj_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        bytes_out++;
        if (restored_q.size() == 0) begin
          $display("%0t: out_byte %02h out_last %0b with no item expected",
                   $time, out_byte, out_last);
          errors++;
        end else begin
          want = restored_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want.data, out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b, actual %0b", $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        items_in++;
        unfilter_step(data_byte, end_of_stream);
        case (pend_chk)
          CHK_PRED: begin
            foreach (step_out[i]) restored_q.push_back(step_out[i]);
          end
          CHK_ONE: begin
            want.data = pend_byte;
            want.last = pend_last;
            restored_q.push_back(want);
          end
          default: begin
          end
        endcase
        step_out.delete();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("x86_call_jump_address_unfilter_core: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos, input chk_e chk,
                           input logic [7:0] eb, input logic el);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    pend_chk      <= chk;
    pend_byte     <= eb;
    pend_last     <= el;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off input until every restored byte has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (restored_q.size() != 0);
  endtask

  task automatic settle();
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write, then read back
  task automatic reg_write(input logic reg_sel, input logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    reg_writes++;
    if (reg_sel == x86cj_pkg::REG_OPERAND_MODE) begin
      wide_call = val[0];
      want = {31'b0, val[0]};
    end else begin
      start_pos = val;
      head_pos  = val;
      want = val;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: prdata at %0d expected %08h, actual %08h",
               $time, {reg_sel, 2'b00}, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // start positions lean on the wrap point
  function automatic logic [31:0] pick_start();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    plan_row_t   plan [PLAN_ROWS];
    logic [7:0]  b;
    logic        eos;
    int          ph;
    int          i;
    for (i = 0; i < x86cj_pkg::WINDOW_BYTES; i++) win[i] = 8'h00;
    plan = '{
      // data extremes pass straight through
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_ONE,  8'h00, 1'b0},
      '{ROW_ITEM,  8'hFF, 1'b0, 32'h0, CHK_ONE,  8'hFF, 1'b0},
      // call with all-ones operand, jump queued behind it
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'hFF, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'hFF, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_JUMP, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_PRED, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      // run of calls: operand bytes are skipped, tail flushed untranslated
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_PRED, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b1, 32'h0, CHK_PRED, 8'h00, 1'b0},
      // one-byte stream that is an opcode
      '{ROW_ITEM,  x86cj_pkg::OPC_JUMP, 1'b1, 32'h0, CHK_ONE,  x86cj_pkg::OPC_JUMP, 1'b1},
      // wide call at the top of the position range
      '{ROW_MODE,  8'h00, 1'b0, 32'h1, CHK_NONE, 8'h00, 1'b0},
      '{ROW_START, 8'h00, 1'b0, 32'hFFFF_FFFF, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  x86cj_pkg::OPC_CALL, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h01, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_ITEM,  8'h00, 1'b1, 32'h0, CHK_PRED, 8'h00, 1'b0},
      '{ROW_MODE,  8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0},
      '{ROW_START, 8'h00, 1'b0, 32'h0, CHK_NONE, 8'h00, 1'b0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].kind)
        ROW_ITEM: begin
          send_byte(plan[i].data, plan[i].eos, plan[i].chk, plan[i].exp_byte, plan[i].exp_last);
        end
        ROW_MODE: begin
          settle();
          reg_write(x86cj_pkg::REG_OPERAND_MODE, plan[i].value);
        end
        default: begin
          settle();
          reg_write(x86cj_pkg::REG_START_POSITION, plan[i].value);
        end
      endcase
    end

    // random streams under four traffic shapes
    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 68; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 68; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      reg_write(x86cj_pkg::REG_OPERAND_MODE, {31'b0, 1'($urandom_range(1))});
      reg_write(x86cj_pkg::REG_START_POSITION, pick_start());
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // mid-phase register change, possibly with bytes held in the window
        if (i == PHASE_ITEMS / 2) begin
          settle();
          reg_write(x86cj_pkg::REG_OPERAND_MODE, {31'b0, ~wide_call});
          if ($urandom_range(1) == 1) reg_write(x86cj_pkg::REG_START_POSITION, pick_start());
        end
        if ((ph == 0 && i == 20) || $urandom_range(99) < 2) drain_outputs();
        case ($urandom_range(9))
          0, 1:    b = x86cj_pkg::OPC_CALL;
          2:       b = x86cj_pkg::OPC_JUMP;
          default: b = 8'($urandom);
        endcase
        eos = (ph == 3 && i == PHASE_ITEMS - 1) || ($urandom_range(99) < 7);
        send_byte(b, eos, CHK_PRED, 8'h00, 1'b0);
      end
    end

    // wait out the last restored bytes
    send_idle  = 0;
    recv_stall = 0;
    drain_outputs();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input items, %0d restored bytes, %0d stream ends, %0d reg writes",
             items_in, bytes_out, stream_ends, reg_writes);
    $display("operand translations: %0d, of them %0d with 32-bit call operands",
             translations, wide_translations);
    if (errors == 0 && restored_q.size() == 0) begin
      $display("x86_call_jump_address_unfilter_core: match");
    end else begin
      $display("x86_call_jump_address_unfilter_core: mismatch");
    end
    $finish;
  end

endmodule

/* x86_call_jump_address_unfilter_core.f */
hw/rtl/x86cj_pkg.sv
hw/rtl/x86cj_window.sv
hw/rtl/x86_call_jump_address_unfilter_core.sv
tb/sv/tb_top.sv
